// ===== design/pan_tilt_tracking_controller_assert.svh =====
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef PAN_TILT_TRACKING_CONTROLLER_ASSERT_SVH
`define PAN_TILT_TRACKING_CONTROLLER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/ptc_pkg.sv =====
package ptc_pkg;

	// Fixed-point formats.
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int GAIN_FRAC_BITS  = 16;
	localparam int ERR_FRAC_BITS   = 4;
	localparam int SQ_SHIFT        = 2 * (ERR_FRAC_BITS + GAIN_FRAC_BITS) - ANGLE_FRAC_BITS;

	// Field widths.
	localparam int ANGLE_W = 17;
	localparam int ERR_W   = 17;
	localparam int CHG_W   = 18;
	localparam int GAIN_W  = 16;
	localparam int CMD_W   = 3;
	localparam int MUL_W   = 32;
	localparam int PROD_W  = 2 * MUL_W;
	// Angle plus two capped squared terms fits comfortably in this width.
	localparam int ACC_W   = 56;

	// Squared-term magnitude used when the gain product overflows 32 bits.
	localparam logic [PROD_W-1:0] SQ_CAP = PROD_W'(1) << 52;

	// Offsets saturate to +-180 degrees.
	localparam logic signed [ANGLE_W-1:0] OFS_LIMIT = ANGLE_W'(180 * (1 << ANGLE_FRAC_BITS));

	// Register file.
	localparam int NUM_REGS = 8;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(NUM_REGS * 4);
	localparam int IDX_W    = $clog2(NUM_REGS);

	localparam logic [GAIN_W-1:0] RST_PAN_KP  = GAIN_W'(5243);
	localparam logic [GAIN_W-1:0] RST_PAN_KD  = GAIN_W'(14418);
	localparam logic [GAIN_W-1:0] RST_TILT_KP = GAIN_W'(6554);
	localparam logic [GAIN_W-1:0] RST_TILT_KD = GAIN_W'(14418);
	localparam logic signed [ANGLE_W-1:0] RST_PAN_UP  = ANGLE_W'(50 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [ANGLE_W-1:0] RST_PAN_LO  = ANGLE_W'(-50 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [ANGLE_W-1:0] RST_TILT_UP = ANGLE_W'(85 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [ANGLE_W-1:0] RST_TILT_LO = ANGLE_W'(-20 * (1 << ANGLE_FRAC_BITS));

	typedef enum logic [IDX_W-1:0] {
		REG_PAN_KP  = 3'd0,
		REG_PAN_KD  = 3'd1,
		REG_TILT_KP = 3'd2,
		REG_TILT_KD = 3'd3,
		REG_PAN_UP  = 3'd4,
		REG_PAN_LO  = 3'd5,
		REG_TILT_UP = 3'd6,
		REG_TILT_LO = 3'd7
	} reg_idx_t;

	// Commands carried by a request beat.
	typedef enum logic [CMD_W-1:0] {
		CMD_TRACK_NEW = 3'd0,
		CMD_TRACK     = 3'd1,
		CMD_MOVE_ABS  = 3'd2,
		CMD_MOVE_OFS  = 3'd3,
		CMD_CLEAR     = 3'd4
	} cmd_t;

	// Squared terms, in the order the sequencer walks them.
	localparam int TERM_W = 2;
	localparam logic [TERM_W-1:0] TERM_PAN_P  = 2'd0;
	localparam logic [TERM_W-1:0] TERM_PAN_D  = 2'd1;
	localparam logic [TERM_W-1:0] TERM_TILT_P = 2'd2;
	localparam logic [TERM_W-1:0] TERM_TILT_D = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_SQUARE,
		ST_ACC,
		ST_CLAMP,
		ST_DONE
	} state_t;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic [GAIN_W-1:0]         pan_kp;
		logic [GAIN_W-1:0]         pan_kd;
		logic [GAIN_W-1:0]         tilt_kp;
		logic [GAIN_W-1:0]         tilt_kd;
		logic signed [ANGLE_W-1:0] pan_upper_limit;
		logic signed [ANGLE_W-1:0] pan_lower_limit;
		logic signed [ANGLE_W-1:0] tilt_upper_limit;
		logic signed [ANGLE_W-1:0] tilt_lower_limit;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;
		logic              mul_gain;
		logic              mul_sq;
		logic              acc;
		logic              clamp;
		logic              out_load;
		logic [TERM_W-1:0] term;
	} dp_cmd_t;

endpackage

// ===== design/ptc_if.sv =====
// Request channel: one command beat.
interface ptc_req_if;
	logic                                      valid;
	logic                                      ready;
	logic [ptc_pkg::CMD_W-1:0]                 cmd;
	logic signed [ptc_pkg::ANGLE_W-1:0]        pan_value;
	logic signed [ptc_pkg::ANGLE_W-1:0]        tilt_value;

	modport source (output valid, output cmd, output pan_value, output tilt_value, input ready);
	modport sink (input valid, input cmd, input pan_value, input tilt_value, output ready);
endinterface

// Result channel: one angle pair beat.
interface ptc_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [ptc_pkg::ANGLE_W-1:0] pan_angle_out;
	logic signed [ptc_pkg::ANGLE_W-1:0] tilt_angle_out;

	modport source (output valid, output pan_angle_out, output tilt_angle_out, input ready);
	modport sink (input valid, input pan_angle_out, input tilt_angle_out, output ready);
endinterface

// ===== design/ptc_regs.sv =====
module ptc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0]   paddr,
	input  logic [ptc_pkg::DATA_W-1:0]   pwdata,
	output logic [ptc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output ptc_pkg::cfg_t                cfg
);

	ptc_pkg::cfg_t     cfg_q;
	ptc_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = ptc_pkg::reg_idx_t'(paddr[ptc_pkg::ADDR_W-1:2]);
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pan_kp           <= ptc_pkg::RST_PAN_KP;
			cfg_q.pan_kd           <= ptc_pkg::RST_PAN_KD;
			cfg_q.tilt_kp          <= ptc_pkg::RST_TILT_KP;
			cfg_q.tilt_kd          <= ptc_pkg::RST_TILT_KD;
			cfg_q.pan_upper_limit  <= ptc_pkg::RST_PAN_UP;
			cfg_q.pan_lower_limit  <= ptc_pkg::RST_PAN_LO;
			cfg_q.tilt_upper_limit <= ptc_pkg::RST_TILT_UP;
			cfg_q.tilt_lower_limit <= ptc_pkg::RST_TILT_LO;
		end else if (wr_en) begin
			case (idx)
				ptc_pkg::REG_PAN_KP: begin
					cfg_q.pan_kp <= pwdata[ptc_pkg::GAIN_W-1:0];
				end
				ptc_pkg::REG_PAN_KD: begin
					cfg_q.pan_kd <= pwdata[ptc_pkg::GAIN_W-1:0];
				end
				ptc_pkg::REG_TILT_KP: begin
					cfg_q.tilt_kp <= pwdata[ptc_pkg::GAIN_W-1:0];
				end
				ptc_pkg::REG_TILT_KD: begin
					cfg_q.tilt_kd <= pwdata[ptc_pkg::GAIN_W-1:0];
				end
				ptc_pkg::REG_PAN_UP: begin
					cfg_q.pan_upper_limit <= pwdata[ptc_pkg::ANGLE_W-1:0];
				end
				ptc_pkg::REG_PAN_LO: begin
					cfg_q.pan_lower_limit <= pwdata[ptc_pkg::ANGLE_W-1:0];
				end
				ptc_pkg::REG_TILT_UP: begin
					cfg_q.tilt_upper_limit <= pwdata[ptc_pkg::ANGLE_W-1:0];
				end
				ptc_pkg::REG_TILT_LO: begin
					cfg_q.tilt_lower_limit <= pwdata[ptc_pkg::ANGLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read mux; gains are zero-extended and limits sign-extended.
	always_comb begin
		case (idx)
			ptc_pkg::REG_PAN_KP:  prdata = ptc_pkg::DATA_W'(cfg_q.pan_kp);
			ptc_pkg::REG_PAN_KD:  prdata = ptc_pkg::DATA_W'(cfg_q.pan_kd);
			ptc_pkg::REG_TILT_KP: prdata = ptc_pkg::DATA_W'(cfg_q.tilt_kp);
			ptc_pkg::REG_TILT_KD: prdata = ptc_pkg::DATA_W'(cfg_q.tilt_kd);
			ptc_pkg::REG_PAN_UP:  prdata = ptc_pkg::DATA_W'(cfg_q.pan_upper_limit);
			ptc_pkg::REG_PAN_LO:  prdata = ptc_pkg::DATA_W'(cfg_q.pan_lower_limit);
			ptc_pkg::REG_TILT_UP: prdata = ptc_pkg::DATA_W'(cfg_q.tilt_upper_limit);
			ptc_pkg::REG_TILT_LO: prdata = ptc_pkg::DATA_W'(cfg_q.tilt_lower_limit);
			default:              prdata = '0;
		endcase
	end

endmodule

// ===== design/ptc_ctrl.sv =====
module ptc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [ptc_pkg::CMD_W-1:0]  in_cmd,
	output logic                       in_ready,
	input  logic                       out_ready,
	output logic                       out_valid,
	output ptc_pkg::dp_cmd_t           dp_cmd
);

	ptc_pkg::state_t              state_q, state_d;
	logic [ptc_pkg::TERM_W-1:0]   term_q, term_d;
	logic                         out_valid_q;

	assign out_valid = out_valid_q;

	// State, term counter and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptc_pkg::ST_IDLE;
			term_q      <= ptc_pkg::TERM_PAN_P;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			term_q  <= term_d;
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d         = state_q;
		term_d          = term_q;
		in_ready        = 1'b0;
		dp_cmd          = '0;
		dp_cmd.term     = term_q;
		case (state_q)
			ptc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.load = 1'b1;
					term_d      = ptc_pkg::TERM_PAN_P;
					case (in_cmd)
						ptc_pkg::CMD_TRACK_NEW, ptc_pkg::CMD_TRACK: state_d = ptc_pkg::ST_GAIN;
						ptc_pkg::CMD_MOVE_ABS, ptc_pkg::CMD_MOVE_OFS: state_d = ptc_pkg::ST_CLAMP;
						default: state_d = ptc_pkg::ST_DONE;
					endcase
				end
			end
			ptc_pkg::ST_GAIN: begin
				// The previous term's square is added while this term's gain product forms.
				dp_cmd.mul_gain = 1'b1;
				dp_cmd.acc      = (term_q != ptc_pkg::TERM_PAN_P);
				state_d         = ptc_pkg::ST_SQUARE;
			end
			ptc_pkg::ST_SQUARE: begin
				dp_cmd.mul_sq = 1'b1;
				if (term_q == ptc_pkg::TERM_TILT_D) begin
					state_d = ptc_pkg::ST_ACC;
				end else begin
					term_d  = term_q + 1'b1;
					state_d = ptc_pkg::ST_GAIN;
				end
			end
			ptc_pkg::ST_ACC: begin
				dp_cmd.acc = 1'b1;
				state_d    = ptc_pkg::ST_CLAMP;
			end
			ptc_pkg::ST_CLAMP: begin
				dp_cmd.clamp = 1'b1;
				state_d      = ptc_pkg::ST_DONE;
			end
			ptc_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					dp_cmd.out_load = 1'b1;
					state_d         = ptc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/ptc_dp.sv =====
module ptc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ptc_pkg::dp_cmd_t                   cmd,
	input  ptc_pkg::cfg_t                      cfg,
	input  logic [ptc_pkg::CMD_W-1:0]          in_cmd,
	input  logic signed [ptc_pkg::ANGLE_W-1:0] in_pan,
	input  logic signed [ptc_pkg::ANGLE_W-1:0] in_tilt,
	output logic signed [ptc_pkg::ANGLE_W-1:0] pan_out,
	output logic signed [ptc_pkg::ANGLE_W-1:0] tilt_out
);

	localparam int AW = ptc_pkg::ANGLE_W;
	localparam int CW = ptc_pkg::CHG_W;
	localparam int XW = ptc_pkg::ACC_W;
	localparam int MW = ptc_pkg::MUL_W;
	localparam int PW = ptc_pkg::PROD_W;

	// Architectural state.
	logic signed [AW-1:0] pan_angle_q, tilt_angle_q;
	logic signed [AW-1:0] pan_err_q, tilt_err_q;
	logic signed [CW-1:0] pan_chg_q, tilt_chg_q;

	// Working registers.
	logic signed [XW-1:0] pan_acc_q, tilt_acc_q;
	logic [PW-1:0]        mul_q;
	logic                 cap_q, term_neg_q, term_tilt_q;
	logic signed [AW-1:0] pan_out_q, tilt_out_q;

	logic signed [CW-1:0]         x;
	logic [CW-1:0]                mag;
	logic [ptc_pkg::GAIN_W-1:0]   gain;
	logic                         x_tilt, x_neg;
	logic [MW-1:0]                mul_a, mul_b;
	logic [PW-1:0]                prod;
	logic [XW-1:0]                term_mag;
	logic signed [XW-1:0]         term_val;
	logic signed [AW-1:0]         pan_sat, tilt_sat;

	function automatic logic signed [AW-1:0] sat_offset(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] r;
		r = v;
		if (v > ptc_pkg::OFS_LIMIT) begin
			r = ptc_pkg::OFS_LIMIT;
		end else if (v < -ptc_pkg::OFS_LIMIT) begin
			r = -ptc_pkg::OFS_LIMIT;
		end
		return r;
	endfunction

	// Upper limit wins first, then the lower one.
	function automatic logic signed [AW-1:0] clamp_angle(input logic signed [XW-1:0] a,
			input logic signed [AW-1:0] up, input logic signed [AW-1:0] lo);
		logic signed [AW-1:0] r;
		r = a[AW-1:0];
		if (a > XW'(up)) begin
			r = up;
		end else if (a < XW'(lo)) begin
			r = lo;
		end
		return r;
	endfunction

	assign pan_out  = pan_out_q;
	assign tilt_out = tilt_out_q;
	assign pan_sat  = sat_offset(in_pan);
	assign tilt_sat = sat_offset(in_tilt);

	// Operand of the current term.
	always_comb begin
		case (cmd.term)
			ptc_pkg::TERM_PAN_P: begin
				x = CW'(pan_err_q); gain = cfg.pan_kp; x_tilt = 1'b0;
			end
			ptc_pkg::TERM_PAN_D: begin
				x = pan_chg_q; gain = cfg.pan_kd; x_tilt = 1'b0;
			end
			ptc_pkg::TERM_TILT_P: begin
				x = CW'(tilt_err_q); gain = cfg.tilt_kp; x_tilt = 1'b1;
			end
			default: begin
				x = tilt_chg_q; gain = cfg.tilt_kd; x_tilt = 1'b1;
			end
		endcase
	end

	// Tilt terms take the opposite sign of their operand.
	assign x_neg = x_tilt ? (!x[CW-1] && (x != '0)) : x[CW-1];
	assign mag   = x[CW-1] ? CW'(-x) : CW'(x);

	// The shared multiplier: gain product first, then its square.
	assign mul_a = cmd.mul_sq ? mul_q[MW-1:0] : MW'(mag);
	assign mul_b = cmd.mul_sq ? mul_q[MW-1:0] : MW'(gain);
	assign prod  = PW'(mul_a) * PW'(mul_b);

	// Signed squared term from the registered square.
	assign term_mag = cap_q ? XW'(ptc_pkg::SQ_CAP) : XW'(mul_q >> ptc_pkg::SQ_SHIFT);
	assign term_val = term_neg_q ? -signed'(term_mag) : signed'(term_mag);

	// Multiplier pipeline and term tags.
	always_ff @(posedge clk) begin
		if (cmd.mul_gain) begin
			mul_q       <= prod;
			term_neg_q  <= x_neg;
			term_tilt_q <= x_tilt;
		end else if (cmd.mul_sq) begin
			mul_q <= prod;
			cap_q <= (mul_q[PW-1:MW] != '0);
		end
	end

	// Angle accumulators.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (in_cmd)
				ptc_pkg::CMD_MOVE_ABS: begin
					pan_acc_q  <= XW'(in_pan);
					tilt_acc_q <= XW'(in_tilt);
				end
				ptc_pkg::CMD_MOVE_OFS: begin
					pan_acc_q  <= XW'(pan_angle_q) + XW'(pan_sat);
					tilt_acc_q <= XW'(tilt_angle_q) + XW'(tilt_sat);
				end
				default: begin
					pan_acc_q  <= XW'(pan_angle_q);
					tilt_acc_q <= XW'(tilt_angle_q);
				end
			endcase
		end else if (cmd.acc) begin
			if (term_tilt_q) begin
				tilt_acc_q <= tilt_acc_q + term_val;
			end else begin
				pan_acc_q <= pan_acc_q + term_val;
			end
		end
	end

	// Errors and their change, updated as a new-error tracking command or a clear is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_err_q  <= '0;
			tilt_err_q <= '0;
			pan_chg_q  <= '0;
			tilt_chg_q <= '0;
		end else if (cmd.load) begin
			case (in_cmd)
				ptc_pkg::CMD_TRACK_NEW: begin
					pan_chg_q  <= CW'(in_pan) - CW'(pan_err_q);
					tilt_chg_q <= CW'(in_tilt) - CW'(tilt_err_q);
					pan_err_q  <= in_pan;
					tilt_err_q <= in_tilt;
				end
				ptc_pkg::CMD_CLEAR: begin
					pan_err_q  <= '0;
					tilt_err_q <= '0;
					pan_chg_q  <= '0;
					tilt_chg_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Commanded angles after clamping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_angle_q  <= '0;
			tilt_angle_q <= '0;
		end else if (cmd.clamp) begin
			pan_angle_q  <= clamp_angle(pan_acc_q, cfg.pan_upper_limit, cfg.pan_lower_limit);
			tilt_angle_q <= clamp_angle(tilt_acc_q, cfg.tilt_upper_limit, cfg.tilt_lower_limit);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pan_out_q  <= pan_angle_q;
			tilt_out_q <= tilt_angle_q;
		end
	end

endmodule

// ===== design/pan_tilt_tracking_controller.sv =====
// Pan/tilt tracking controller.
// A request beat carries cmd, pan_value and tilt_value; each request yields exactly
// one result beat with the pan and tilt angles after the command. Gains and angle
// limits sit in an APB register file (4 bytes per register, pready tied high); the
// user must write them only while no command is in flight; the block does not enforce it.
// A tracking command (cmd 0 and 1) runs a gain step and a square step for each of
// the four terms, then accumulate, clamp and done; an absolute or offset move goes
// to clamp and done, and clearing the errors or an unused code goes straight to done.
// Tracking uses the single 32x32 multiplier, which forms the gain product and then
// its square for each of the four terms. One command is worked on at a time; the
// next can be taken in the cycle after its result is loaded into the output register.
// Reset clears the angles, errors and error changes to zero and loads the default
// gains and limits. If the receiver stalls, the result stays in the output register
// and the block still takes and works the next command; that command's result then
// waits until the pending beat is taken.
module pan_tilt_tracking_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	ptc_req_if.sink                    request,
	ptc_res_if.source                  result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0] paddr,
	input  logic [ptc_pkg::DATA_W-1:0] pwdata,
	output logic [ptc_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	ptc_pkg::cfg_t    cfg;
	ptc_pkg::dp_cmd_t dp_cmd;

	// Configuration registers.
	ptc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	ptc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_cmd    (request.cmd),
		.in_ready  (request.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.dp_cmd    (dp_cmd)
	);

	// Arithmetic and state.
	ptc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.cfg      (cfg),
		.in_cmd   (request.cmd),
		.in_pan   (request.pan_value),
		.in_tilt  (request.tilt_value),
		.pan_out  (result.pan_angle_out),
		.tilt_out (result.tilt_angle_out)
	);

endmodule

// ===== design/ptc_checker.sv =====
`include "pan_tilt_tracking_controller_assert.svh"

module ptc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic signed [ptc_pkg::ANGLE_W-1:0] res_pan,
	input logic signed [ptc_pkg::ANGLE_W-1:0] res_tilt
);

	// One command at a time: the block is busy right after taking a request.
	`PTC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

	// A new result only appears while the block was working on a command.
	`PTC_ASSERT_NOW(a_result_from_work, $rose(res_valid), !$past(req_ready), "result while idle")

	// A stalled result beat stays offered.
	`PTC_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid, "result dropped")

	// A stalled result beat keeps its angles.
	`PTC_ASSERT_NEXT(a_result_stable, res_valid && !res_ready,
		$stable(res_pan) && $stable(res_tilt), "result changed")

endmodule

bind pan_tilt_tracking_controller ptc_checker u_ptc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_pan   (result.pan_angle_out),
	.res_tilt  (result.tilt_angle_out)
);
